// ===== src/u8ng_pkg.sv =====
package u8ng_pkg;

   localparam int MAX_GRAM   = 8;
   localparam int SLOT_W     = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
   localparam int CNT_W      = $clog2(MAX_GRAM + 1);
   localparam int CHAR_BYTES = 4;

   // lead byte class boundaries
   localparam logic [7:0] CONT_BASE  = 8'h80;
   localparam logic [7:0] TWO_BASE   = 8'hC0;
   localparam logic [7:0] THREE_BASE = 8'hE0;
   localparam logic [7:0] FOUR_BASE  = 8'hF0;
   localparam logic [7:0] BAD_BASE   = 8'hF8;

   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   typedef logic [CHAR_BYTES-1:0][7:0] char_type;
   typedef logic [2:0] char_len_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // continuation bytes still expected after this lead byte
   function automatic logic [1:0] extra_bytes(logic [7:0] b);
      logic [1:0] n;
      priority if (b < CONT_BASE)  n = 2'd0;
      else if (b < TWO_BASE)       n = 2'd0;
      else if (b < THREE_BASE)     n = 2'd1;
      else if (b < FOUR_BASE)      n = 2'd2;
      else if (b < BAD_BASE)       n = 2'd3;
      else                         n = 2'd0;
      return n;
   endfunction

   function automatic logic [CNT_W-1:0] eff_gram(logic [3:0] g);
      logic [CNT_W-1:0] n;
      if (g == 4'd0)               n = CNT_W'(1);
      else if (32'(g) > MAX_GRAM)  n = CNT_W'(MAX_GRAM);
      else                         n = CNT_W'(g);
      return n;
   endfunction

endpackage

// ===== src/u8ng_if.sv =====
interface u8ng_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_value;

   modport source (output valid, kind, byte_value, input ready);
   modport sink   (input valid, kind, byte_value, output ready);
endinterface

interface u8ng_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       gram_end;

   modport source (output valid, out_byte, gram_end, input ready);
   modport sink   (input valid, out_byte, gram_end, output ready);
endinterface

// ===== src/utf8_char_ngram_extractor_top.sv =====
// channel   dir  payload                      handshake
// req_bus   in   kind, byte_value             valid/ready
// rsp_bus   out  out_byte, gram_end           valid/ready
// csr       in   csr_wr_data[3:0] gram length csr_wr_en, no wait
//
// A request is taken whenever the block is idle. When it completes a character and the
// line holds enough characters, the block is busy while it emits N to 4N bytes (at most
// 32 at N = 8): the emit sequencer walks the window one byte a cycle through the single
// output register, and rsp stalls hold it back. req ready returns the cycle after
// the last byte is loaded. Synchronous reset; the window itself is never cleared, only
// its head and count.
module utf8_char_ngram_extractor_top (
   input  logic       clock,
   input  logic       reset,
   u8ng_req_if.sink   req_bus,
   u8ng_rsp_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);
   import u8ng_pkg::*;

   state_type          state_ff, state_in;
   logic [3:0]         gram_ff, gram_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   char_type           part_char_ff, part_char_in;
   char_len_type       part_len_ff, part_len_in;
   logic [1:0]         need_ff, need_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [1:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_end_ff, rsp_end_in;

   char_type           win_char_ff [MAX_GRAM];
   char_len_type       win_len_ff  [MAX_GRAM];

   logic               req_fire;
   logic               rsp_free;
   logic               commit;
   logic               win_we;
   char_type           c_char;
   char_len_type       c_len;
   logic [SLOT_W-1:0]  head_inc;
   logic [CNT_W-1:0]   cnt_inc;
   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W:0]     base_x, k_x, slot_x;
   logic [SLOT_W-1:0]  rd_slot;
   char_type           rd_char;
   char_len_type       rd_len;
   logic               last_byte;

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign req_fire         = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.gram_end = rsp_end_ff;
   assign rsp_free         = !rsp_valid_ff || rsp_bus.ready;

   assign gram_in  = csr_wr_en ? csr_wr_data : gram_ff;
   assign n_eff    = eff_gram(gram_ff);
   assign head_inc = (head_ff == SLOT_W'(MAX_GRAM - 1)) ? '0 : head_ff + 1'b1;
   assign cnt_inc  = (cnt_ff < CNT_W'(MAX_GRAM)) ? cnt_ff + 1'b1 : cnt_ff;

   // slot of the k-th newest character, modulo the window depth
   assign base_x  = (CNT_W + 1)'(base_ff);
   assign k_x     = (CNT_W + 1)'(k_ff);
   assign slot_x  = (base_x >= k_x) ? base_x - k_x
                                    : base_x + (CNT_W + 1)'(MAX_GRAM) - k_x;
   assign rd_slot = slot_x[SLOT_W-1:0];
   assign rd_char = win_char_ff[rd_slot];
   assign rd_len  = win_len_ff[rd_slot];
   assign last_byte = ({1'b0, idx_ff} + 3'd1) >= rd_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gram_ff      <= 4'd1;
         head_ff      <= '0;
         cnt_ff       <= '0;
         part_char_ff <= '0;
         part_len_ff  <= '0;
         need_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gram_ff      <= gram_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         part_char_ff <= part_char_in;
         part_len_ff  <= part_len_in;
         need_ff      <= need_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      k_ff        <= k_in;
      idx_ff      <= idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_char_ff[head_ff] <= c_char;
         win_len_ff[head_ff]  <= c_len;
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      part_char_in = part_char_ff;
      part_len_in  = part_len_ff;
      need_in      = need_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      commit       = 1'b0;
      win_we       = 1'b0;
      c_char       = part_char_ff;
      c_len        = part_len_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.kind == KIND_EOL) begin
                  // flush a truncated character with the bytes present
                  commit = (part_len_ff != '0);
               end else begin
                  if (need_ff == 2'd0) begin
                     c_char    = '0;
                     c_char[0] = req_bus.byte_value;
                     c_len     = char_len_type'(1);
                     need_in   = extra_bytes(req_bus.byte_value);
                  end else begin
                     c_char[part_len_ff[1:0]] = req_bus.byte_value;
                     c_len   = part_len_ff + 1'b1;
                     need_in = need_ff - 1'b1;
                  end
                  part_char_in = c_char;
                  part_len_in  = c_len;
                  commit       = (need_in == 2'd0);
               end

               if (commit) begin
                  win_we       = 1'b1;
                  part_char_in = '0;
                  part_len_in  = '0;
                  need_in      = '0;
                  head_in      = head_inc;
                  cnt_in       = cnt_inc;
                  base_in      = head_inc;
                  if (cnt_inc >= n_eff) begin
                     k_in     = n_eff;
                     idx_in   = '0;
                     state_in = ST_EMIT;
                  end
               end

               // window contents stay put; base_ff keeps the emit origin
               if (req_bus.kind == KIND_EOL) begin
                  head_in      = '0;
                  cnt_in       = '0;
                  part_char_in = '0;
                  part_len_in  = '0;
                  need_in      = '0;
               end
            end
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_char[idx_ff];
               rsp_end_in   = last_byte && (k_ff == CNT_W'(1));
               if (last_byte) begin
                  idx_in = '0;
                  k_in   = k_ff - 1'b1;
                  if (k_ff == CNT_W'(1)) state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
      endcase
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_GRAM))
      else $error("line character count above window depth");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (k_ff != '0) && (k_ff <= CNT_W'(MAX_GRAM)))
      else $error("emit character counter out of range");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && rsp_free && last_byte && (k_ff == CNT_W'(1))
      |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_end_ff)
      else $error("gram end not followed by idle");

   a_eol_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_bus.kind == KIND_EOL)
      |=> (head_ff == '0) && (cnt_ff == '0) && (part_len_ff == '0))
      else $error("end of line did not clear the window");

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && !last_byte |=> state_ff == ST_EMIT)
      else $error("emit left mid character");

endmodule
